/* rtl/nsqrt_pkg.sv */
// ----------------------------------------------------------------------------
// nsqrt_pkg
// Shared widths and constants for the eight-lane Newton square root.
// ----------------------------------------------------------------------------
package nsqrt_pkg;

  localparam int unsigned Lanes       = 8;
  localparam int unsigned DefMaxIter  = 32;
  localparam int unsigned DefFracBits = 16;

  localparam int unsigned ValueW = 32;
  localparam int unsigned RootW  = 24;
  localparam int unsigned TolW   = 16;

  localparam logic [TolW-1:0] TolReset = 16'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_OUT
  } state_e;

endpackage

/* rtl/nsqrt_lane.sv */
// ----------------------------------------------------------------------------
// nsqrt_lane
// One lane: holds radicand and guess, runs one restoring-division Newton step
// per load or start pulse, one quotient bit per cycle while div_step_i is high.
// ----------------------------------------------------------------------------
module nsqrt_lane import nsqrt_pkg::*; #(
  parameter int unsigned FracBits = DefFracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [ValueW-1:0] value_i,
  input  logic              start_i,
  input  logic              div_step_i,
  input  logic              finish_i,
  input  logic [TolW-1:0]   tol_i,
  output logic              conv_o,
  output logic [RootW-1:0]  root_o
);

  localparam int unsigned NumW = ValueW + FracBits;
  localparam int unsigned XW   = NumW;

  logic [ValueW-1:0] v_q;
  logic [XW-1:0]     x_q, x_d;
  logic [NumW-1:0]   num_q, quo_q;
  logic [XW-1:0]     rem_q;
  logic [XW:0]       rem_sh;
  logic              zero;
  logic [XW:0]       sum;
  logic [XW-1:0]     diff;

  assign zero   = (v_q == '0);
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign sum    = {1'b0, x_q} + {1'b0, quo_q};
  assign x_d    = (sum[XW:1] == '0) ? XW'(1) : sum[XW:1];
  // change between the current guess and the one this step produces
  assign diff   = (x_q >= x_d) ? x_q - x_d : x_d - x_q;
  assign conv_o = zero || (diff < XW'(tol_i));
  assign root_o = (x_q > XW'({RootW{1'b1}})) ? {RootW{1'b1}} : x_q[RootW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      x_q <= '0;
    end else if (load_i) begin
      v_q <= value_i;
      if (value_i == '0) x_q <= '0;
      else if (value_i[ValueW-1:1] == '0) x_q <= XW'(1);
      else x_q <= XW'(value_i[ValueW-1:1]);
    end else if (finish_i && !zero) begin
      x_q <= x_d;
    end
  end

  // restoring division of (v << FracBits) by x
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
    end else if (load_i) begin
      num_q <= NumW'(value_i) << FracBits;
      rem_q <= '0;
      quo_q <= '0;
    end else if (start_i) begin
      num_q <= NumW'(v_q) << FracBits;
      rem_q <= '0;
      quo_q <= '0;
    end else if (div_step_i) begin
      num_q <= num_q << 1;
      if (rem_sh >= {1'b0, x_q}) begin
        rem_q <= XW'(rem_sh - {1'b0, x_q});
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[XW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/newton_sqrt_eight_lanes.sv */
// ----------------------------------------------------------------------------
// newton_sqrt_eight_lanes
// Eight-lane Newton-Raphson square root, Q16.16 in, Q8.16 out.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o, value_*_i
// out     | output    | out_valid_o / out_stall_i, root_*_o, limit_hit_o
// cfg     | input     | cfg_valid_i / cfg_ready_o, cfg_data_i (tolerance)
// One word at a time. Each Newton step runs bit-serial division in every
// lane (ST_DIV) followed by a check state (ST_CHECK); steps repeat until
// all lanes converge or MaxIter steps are done, then the result is valid
// in ST_OUT. The lane convergence flags are ANDed combinationally.
// Reset sets tolerance to 7. The result is held while out_stall_i is
// high; the next word is taken once it leaves.
module newton_sqrt_eight_lanes import nsqrt_pkg::*; #(
  parameter int unsigned MaxIter  = DefMaxIter,
  parameter int unsigned FracBits = DefFracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_0_i, value_1_i, value_2_i, value_3_i,
  input  logic [ValueW-1:0] value_4_i, value_5_i, value_6_i, value_7_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RootW-1:0]  root_0_o, root_1_o, root_2_o, root_3_o,
  output logic [RootW-1:0]  root_4_o, root_5_o, root_6_o, root_7_o,
  output logic              limit_hit_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TolW-1:0]   cfg_data_i
);

  localparam int unsigned DivBits = ValueW + FracBits;
  localparam int unsigned CntW    = $clog2(DivBits + 1);
  localparam int unsigned ItW     = $clog2(MaxIter + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [ItW-1:0]  it_q;
  logic [TolW-1:0] tol_q;
  logic            limit_q;
  logic [Lanes-1:0] conv;
  logic [ValueW-1:0] vals [Lanes];
  logic [RootW-1:0]  roots [Lanes];
  logic load, start, div_step, finish, all_conv, at_cap;

  assign vals[0] = value_0_i;
  assign vals[1] = value_1_i;
  assign vals[2] = value_2_i;
  assign vals[3] = value_3_i;
  assign vals[4] = value_4_i;
  assign vals[5] = value_5_i;
  assign vals[6] = value_6_i;
  assign vals[7] = value_7_i;

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    nsqrt_lane #(.FracBits(FracBits)) u_lane (
      .clk_i, .rst_ni,
      .load_i(load), .value_i(vals[g]), .start_i(start),
      .div_step_i(div_step), .finish_i(finish), .tol_i(tol_q),
      .conv_o(conv[g]), .root_o(roots[g])
    );
  end

  assign all_conv = &conv;
  // the step being finished is step it_q + 1
  assign at_cap = (it_q >= ItW'(MaxIter - 1));
  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign load = in_valid_i && !in_stall_o;
  assign {root_0_o, root_1_o, root_2_o, root_3_o} = {roots[0], roots[1], roots[2], roots[3]};
  assign {root_4_o, root_5_o, root_6_o, root_7_o} = {roots[4], roots[5], roots[6], roots[7]};
  assign limit_hit_o = limit_q;

  always_comb begin
    state_d = state_q;
    start = 1'b0;
    div_step = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (load) state_d = ST_DIV;
      end
      ST_DIV: begin
        div_step = 1'b1;
        if (cnt_q == CntW'(DivBits - 1)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // apply the new guess and decide on another step
        finish = 1'b1;
        if (all_conv || at_cap) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIV;
          start = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      it_q <= '0;
      limit_q <= 1'b0;
      tol_q <= TolReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) tol_q <= cfg_data_i;
      if (state_q == ST_DIV) cnt_q <= cnt_q + CntW'(1);
      else cnt_q <= '0;
      if (load) begin
        it_q <= '0;
        limit_q <= 1'b0;
      end else if (finish) begin
        it_q <= it_q + ItW'(1);
        if (!all_conv && at_cap) limit_q <= 1'b1;
      end
    end
  end

endmodule
